### sv/sblq_pkg.sv
// Package for the shared-buffer linked queues block: sizes, codes, the
// controller/datapath command and status structs and small pointer helpers.
// Depends on nothing; every other file imports it.
package sblq_pkg;

  localparam int ENTRIES    = 16;
  localparam int NUM_QUEUES = 2;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PTR_W = $clog2(ENTRIES + 1);
  localparam int QID_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  // The null pointer is the code one past the last entry.
  localparam ptr_t NULL_PTR = PTR_W'(ENTRIES);

  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_DEQ  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Link store read address select.
  localparam logic [1:0] RA_FREE = 2'd0;
  localparam logic [1:0] RA_TAIL = 2'd1;
  localparam logic [1:0] RA_RD   = 2'd2;

  // Link store write address select.
  localparam logic WA_PTR  = 1'b0;
  localparam logic WA_TAIL = 1'b1;

  // Link store write data select.
  localparam logic [1:0] WD_PTR  = 2'd0;
  localparam logic [1:0] WD_RD   = 2'd1;
  localparam logic [1:0] WD_FREE = 2'd2;

  typedef struct packed {
    logic       latch_in;
    logic [1:0] rd_sel;
    logic       ptr_ld_free;
    logic       ptr_ld_rd;
    logic       pay_wr;
    logic       link_wr;
    logic       link_wa;
    logic [1:0] link_wd;
    logic       free_ld_rd;
    logic       free_ld_ptr;
    logic       tail_ld_ptr;
    logic       tail_ld_null;
    logic       res_ld;
    logic [1:0] res_status;
    logic       word_clr;
    logic       word_ld;
    logic       out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic mode_enq;
    logic mode_peek;
    logic mode_bad;
    logic qid_bad;
    logic free_empty;
    logic tail_empty;
    logic head_bad;
    logic head_eq_tail;
  } dp_stat_t;

  function automatic logic is_entry(input ptr_t p);
    return p < NULL_PTR;
  endfunction

  // Link value an entry holds straight after reset: the next entry, or null
  // for the last one.
  function automatic ptr_t link_init(input idx_t i);
    return (32'(i) == ENTRIES - 1) ? NULL_PTR : PTR_W'(32'(i) + 1);
  endfunction

endpackage

### sv/shared_buffer_linked_queues_unit.sv
// Top level of the shared-buffer linked queues block.
// Depends on sblq_pkg, sblq_ctrl and sblq_dpath.
//
// Several FIFO queues share one store of ENTRIES entries. Each queue is a
// circular linked list of which only the tail is kept; the tail's link names
// the head. Unused entries sit on a free list. Each item enqueues, dequeues
// or peeks on one queue and produces exactly one result item carrying a status
// (ok, store full, queue empty) and the head word for a successful dequeue or
// peek, zero otherwise. One item is worked on at a time: a new item is not
// accepted until the result of the one before has moved into the output
// register, which waits while the output side stalls. The link store has one
// write and one registered read port, so the chain of dependent link reads
// and write-backs runs one access per cycle. After reset every entry's link
// holds its reset value at once (per-entry valid bits), so no clearing pass
// is needed; the payload store has no reset and an entry is only ever read
// after it has been written.
module shared_buffer_linked_queues_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_mode,
  input  logic                            in_queue_id,
  input  logic [sblq_pkg::DATA_WIDTH-1:0] in_payload_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [sblq_pkg::DATA_WIDTH-1:0] out_payload_out
);
  import sblq_pkg::*;

  // Command and status between the sequencer and the stores.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller owns both handshakes and the order of store accesses.
  sblq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the stores, the queue pointers and the result item.
  sblq_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_mode),
    .in_queue_id     (in_queue_id),
    .in_payload_in   (in_payload_in),
    .out_status      (out_status),
    .out_payload_out (out_payload_out)
  );

endmodule

### sv/sblq_dpath.sv
// Datapath of the shared-buffer linked queues: link and payload stores, tail
// and free-list pointers, operand, result and output registers.
// Depends on sblq_pkg; driven by sblq_ctrl through sblq_pkg::dp_cmd_t.
module sblq_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sblq_pkg::dp_cmd_t         cmd,
  output sblq_pkg::dp_stat_t        stat,
  input  logic [1:0]                in_mode,
  input  logic                      in_queue_id,
  input  logic [sblq_pkg::DATA_WIDTH-1:0] in_payload_in,
  output logic [1:0]                out_status,
  output logic [sblq_pkg::DATA_WIDTH-1:0] out_payload_out
);
  import sblq_pkg::*;

  logic [1:0]   op_mode_r;
  logic         op_qid_r;
  word_t        op_word_r;

  ptr_t         tail_r [NUM_QUEUES];
  ptr_t         free_head_r;
  ptr_t         ptr_r;

  ptr_t         link_mem [ENTRIES];
  word_t        pay_mem  [ENTRIES];
  logic [ENTRIES-1:0] lvalid_r;

  ptr_t         link_q_r;
  ptr_t         dflt_q_r;
  logic         lv_q_r;
  word_t        pay_q_r;

  logic [1:0]   res_status_r;
  word_t        res_word_r;
  logic [1:0]   out_status_r;
  word_t        out_word_r;

  logic [QID_W-1:0] qidx;
  ptr_t         tail_sel;
  ptr_t         rdlink;
  ptr_t         rd_ptr;
  ptr_t         wa_ptr;
  ptr_t         wd;
  idx_t         ra;
  idx_t         wa;

  assign qidx     = QID_W'(op_qid_r);
  assign tail_sel = tail_r[qidx];

  // An entry whose link was never written still holds its reset link.
  assign rdlink = lv_q_r ? link_q_r : dflt_q_r;

  always_comb begin
    case (cmd.rd_sel)
      RA_FREE: rd_ptr = free_head_r;
      RA_TAIL: rd_ptr = tail_sel;
      RA_RD:   rd_ptr = rdlink;
      default: rd_ptr = tail_sel;
    endcase
  end

  always_comb begin
    case (cmd.link_wd)
      WD_PTR:  wd = ptr_r;
      WD_RD:   wd = rdlink;
      WD_FREE: wd = free_head_r;
      default: wd = ptr_r;
    endcase
  end

  assign wa_ptr = (cmd.link_wa == WA_TAIL) ? tail_sel : ptr_r;
  assign ra     = rd_ptr[IDX_W-1:0];
  assign wa     = wa_ptr[IDX_W-1:0];

  assign stat.mode_enq     = (op_mode_r == MODE_ENQ);
  assign stat.mode_peek    = (op_mode_r == MODE_PEEK);
  assign stat.mode_bad     = (op_mode_r != MODE_ENQ) && (op_mode_r != MODE_DEQ) &&
                             (op_mode_r != MODE_PEEK);
  assign stat.qid_bad      = (32'(op_qid_r) >= NUM_QUEUES);
  assign stat.free_empty   = !is_entry(free_head_r);
  assign stat.tail_empty   = !is_entry(tail_sel);
  assign stat.head_bad     = !is_entry(rdlink);
  assign stat.head_eq_tail = (ptr_r == tail_sel);

  // Stores: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (cmd.link_wr) begin
      link_mem[wa] <= wd;
    end
    if (cmd.pay_wr) begin
      pay_mem[ptr_r[IDX_W-1:0]] <= op_word_r;
    end
    link_q_r <= link_mem[ra];
    dflt_q_r <= link_init(ra);
    lv_q_r   <= lvalid_r[ra];
    pay_q_r  <= pay_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvalid_r    <= '0;
      free_head_r <= '0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        tail_r[q] <= NULL_PTR;
      end
    end else begin
      if (cmd.link_wr) begin
        lvalid_r[wa] <= 1'b1;
      end
      if (cmd.free_ld_rd) begin
        free_head_r <= rdlink;
      end else if (cmd.free_ld_ptr) begin
        free_head_r <= ptr_r;
      end
      if (cmd.tail_ld_ptr) begin
        tail_r[qidx] <= ptr_r;
      end else if (cmd.tail_ld_null) begin
        tail_r[qidx] <= NULL_PTR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_mode_r <= in_mode;
      op_qid_r  <= in_queue_id;
      op_word_r <= in_payload_in;
    end
    if (cmd.ptr_ld_free) begin
      ptr_r <= free_head_r;
    end else if (cmd.ptr_ld_rd) begin
      ptr_r <= rdlink;
    end
    if (cmd.res_ld) begin
      res_status_r <= cmd.res_status;
    end
    if (cmd.word_clr) begin
      res_word_r <= '0;
    end else if (cmd.word_ld) begin
      res_word_r <= pay_q_r;
    end
    if (cmd.out_ld) begin
      out_status_r <= res_status_r;
      out_word_r   <= res_word_r;
    end
  end

  assign out_status      = out_status_r;
  assign out_payload_out = out_word_r;

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= NULL_PTR)
    else $error("free-list head holds neither an entry nor null");

  a_tail_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.link_wr && cmd.link_wa == WA_TAIL) |-> is_entry(tail_sel))
    else $error("link write through an empty tail pointer");

  a_pay_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pay_wr |-> is_entry(ptr_r))
    else $error("payload write to a null entry");

endmodule

### sv/sblq_ctrl.sv
// Controller of the shared-buffer linked queues: sequences each operation
// over the stores, one write and one registered read a cycle, and runs both handshakes.
// Depends on sblq_pkg; commands sblq_dpath through sblq_pkg::dp_cmd_t.
module sblq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  sblq_pkg::dp_stat_t  stat,
  output sblq_pkg::dp_cmd_t   cmd
);
  import sblq_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_E1   = 4'd2;
  localparam logic [3:0] S_E2   = 4'd3;
  localparam logic [3:0] S_E3   = 4'd4;
  localparam logic [3:0] S_D1   = 4'd5;
  localparam logic [3:0] S_D2   = 4'd6;
  localparam logic [3:0] S_D3   = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RA_TAIL;
    state_nxt  = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        cmd.word_clr   = 1'b1;
        cmd.res_ld     = 1'b1;
        cmd.res_status = ST_OK;
        if (stat.mode_bad) begin
          state_nxt = S_DONE;
        end else if (stat.qid_bad) begin
          cmd.res_status = stat.mode_enq ? ST_FULL : ST_EMPTY;
          state_nxt      = S_DONE;
        end else if (stat.mode_enq) begin
          if (stat.free_empty) begin
            cmd.res_status = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            cmd.rd_sel      = RA_FREE;
            cmd.ptr_ld_free = 1'b1;
            state_nxt       = S_E1;
          end
        end else if (stat.tail_empty) begin
          cmd.res_status = ST_EMPTY;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_sel = RA_TAIL;
          state_nxt  = S_D1;
        end
      end
      S_E1: begin
        cmd.free_ld_rd = 1'b1;
        cmd.pay_wr     = 1'b1;
        if (stat.tail_empty) begin
          cmd.link_wr     = 1'b1;
          cmd.link_wa     = WA_PTR;
          cmd.link_wd     = WD_PTR;
          cmd.tail_ld_ptr = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.rd_sel = RA_TAIL;
          state_nxt  = S_E2;
        end
      end
      S_E2: begin
        cmd.link_wr = 1'b1;
        cmd.link_wa = WA_PTR;
        cmd.link_wd = WD_RD;
        state_nxt   = S_E3;
      end
      S_E3: begin
        cmd.link_wr     = 1'b1;
        cmd.link_wa     = WA_TAIL;
        cmd.link_wd     = WD_PTR;
        cmd.tail_ld_ptr = 1'b1;
        state_nxt       = S_DONE;
      end
      S_D1: begin
        if (stat.head_bad) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_EMPTY;
          state_nxt      = S_DONE;
        end else begin
          cmd.ptr_ld_rd = 1'b1;
          cmd.rd_sel    = RA_RD;
          state_nxt     = S_D2;
        end
      end
      S_D2: begin
        cmd.word_ld = 1'b1;
        if (stat.mode_peek) begin
          state_nxt = S_DONE;
        end else begin
          if (stat.head_eq_tail) begin
            cmd.tail_ld_null = 1'b1;
          end else begin
            cmd.link_wr = 1'b1;
            cmd.link_wa = WA_TAIL;
            cmd.link_wd = WD_RD;
          end
          state_nxt = S_D3;
        end
      end
      S_D3: begin
        cmd.link_wr     = 1'b1;
        cmd.link_wa     = WA_PTR;
        cmd.link_wd     = WD_FREE;
        cmd.free_ld_ptr = 1'b1;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_ld ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == S_DEC)
    else $error("accepted item was not decoded next cycle");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (state_r == S_DONE && !(out_valid_r && out_stall)))
    else $error("output register loaded over a waiting result");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken while an item is in progress");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for shared_buffer_linked_queues_unit: a scoreboard class
// predicts every result from its own copy of the queues, the free list and the store.
// Depends on sblq_pkg and the RTL of the block.
module tb;
  import sblq_pkg::*;

  // The two-bit mode field has one code that the block treats as a no-op.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Bias of a stretch of random items.
  typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_t;

  typedef struct {
    logic [1:0] status;
    word_t      word;
  } answer_t;

  // Scoreboard: keeps a private image of the link store, the payload store, the
  // tail pointers and the free list head, works out the answer to every accepted
  // item and compares each returned item with the oldest answer still owed.
  class linked_queue_scoreboard;
    ptr_t    links [ENTRIES];
    word_t   words [ENTRIES];
    ptr_t    tails [NUM_QUEUES];
    ptr_t    free_head;
    answer_t owed [$];
    int      failures;
    int      n_ok, n_full, n_empty, n_checked;

    function new();
      for (int k = 0; k < ENTRIES; k++) begin
        links[k] = (k == ENTRIES - 1) ? NULL_PTR : ptr_t'(k + 1);
        words[k] = '0;
      end
      for (int q = 0; q < NUM_QUEUES; q++) tails[q] = NULL_PTR;
      free_head = '0;
      failures  = 0;
      n_ok      = 0;
      n_full    = 0;
      n_empty   = 0;
      n_checked = 0;
    endfunction

    // Anything at or beyond ENTRIES counts as null.
    function bit holds_entry(ptr_t p);
      return int'(p) < ENTRIES;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function int free_count();
      ptr_t p;
      int   n;
      p = free_head;
      n = 0;
      while (holds_entry(p) && n <= ENTRIES) begin
        n++;
        p = links[idx_t'(p)];
      end
      return n;
    endfunction

    // Applies one accepted item to the image and queues the answer it owes.
    function void note_item(logic [1:0] mode, logic qid, word_t data);
      answer_t a;
      ptr_t    tl, hd, cur;
      int      q;
      a.status = ST_OK;
      a.word   = '0;
      q = int'(qid);
      if (mode == MODE_UNUSED) begin
        // No effect at all.
      end else if (q >= NUM_QUEUES) begin
        a.status = (mode == MODE_ENQ) ? ST_FULL : ST_EMPTY;
      end else if (mode == MODE_ENQ) begin
        cur = free_head;
        tl  = tails[qid];
        if (!holds_entry(cur)) begin
          a.status = ST_FULL;
        end else begin
          free_head          = links[idx_t'(cur)];
          words[idx_t'(cur)] = data;
          if (!holds_entry(tl)) begin
            links[idx_t'(cur)] = cur;
          end else begin
            links[idx_t'(cur)] = links[idx_t'(tl)];
            links[idx_t'(tl)]  = cur;
          end
          tails[qid] = cur;
        end
      end else begin
        tl = tails[qid];
        hd = holds_entry(tl) ? links[idx_t'(tl)] : NULL_PTR;
        if (!holds_entry(tl) || !holds_entry(hd)) begin
          a.status = ST_EMPTY;
        end else begin
          a.word = words[idx_t'(hd)];
          if (mode == MODE_DEQ) begin
            if (hd == tl) tails[qid] = NULL_PTR;
            else links[idx_t'(tl)] = links[idx_t'(hd)];
            links[idx_t'(hd)] = free_head;
            free_head = hd;
          end
        end
      end
      owed.push_back(a);
    endfunction

    function void check_result(logic [1:0] status, word_t word);
      answer_t a;
      if (owed.size() == 0) begin
        $error("result item arrived with nothing owed: status %0d payload_out %h",
               status, word);
        failures++;
        return;
      end
      a = owed.pop_front();
      n_checked++;
      if (a.status == ST_OK) n_ok++;
      else if (a.status == ST_FULL) n_full++;
      else n_empty++;
      if (status !== a.status) begin
        $error("status mismatch: expected %0d, actual %0d", a.status, status);
        failures++;
      end
      if (word !== a.word) begin
        $error("payload_out mismatch: expected %h, actual %h", a.word, word);
        failures++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic        in_queue_id;
  word_t       in_payload_in;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  word_t       out_payload_out;

  linked_queue_scoreboard sb;

  // When this is clear both sides run flat out, giving stretches without gaps.
  bit idling_on;
  int n_sent;
  int n_refills;

  shared_buffer_linked_queues_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_queue_id    (in_queue_id),
    .in_payload_in  (in_payload_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_payload_out(out_payload_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on run time. The slowest correct run is roughly 1500 items,
  // some 0.6 ms; this leaves a wide margin.
  initial begin
    #5ms;
    $display("shared_buffer_linked_queues_unit test failed");
    $finish;
  end

  function automatic int draw_wait();
    return idling_on ? $urandom_range(4) : 0;
  endfunction

  // Offers one item after a random gap and returns at the edge where it is
  // taken. All drives happen just after a rising edge, and every sample taken
  // straight after an edge sees the values from before it.
  task automatic send_item(logic [1:0] mode, logic qid, word_t data);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_queue_id   <= qid;
    in_payload_in <= data;
    do @(posedge clk); while (in_stall);
    sb.note_item(mode, qid, data);
    n_sent++;
  endtask

  // Result side: stalls for a random number of cycles, then takes one item.
  task automatic take_results();
    int hold;
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_status, out_payload_out);
    end
  endtask

  // Holds the sender back until every owed result has come home.
  task automatic drain_all();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic word_t draw_word();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return word_t'($urandom);
  endfunction

  // Picks a mode according to the current bias. The unused code turns up now
  // and then so that both mode bits see every combination.
  function automatic logic [1:0] draw_mode(lean_t lean);
    int r;
    int enq_pct;
    r = $urandom_range(99);
    case (lean)
      LEAN_FILL:  enq_pct = 70;
      LEAN_DRAIN: enq_pct = 20;
      default:    enq_pct = 45;
    endcase
    if (r < 3) return MODE_UNUSED;
    if (r < 3 + 12) return MODE_PEEK;
    if (r < 15 + enq_pct) return MODE_ENQ;
    return MODE_DEQ;
  endfunction

  initial begin
    lean_t lean;
    sb = new();
    n_sent    = 0;
    n_refills = 0;
    idling_on = 1'b1;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_mode       <= MODE_ENQ;
    in_queue_id   <= 1'b0;
    in_payload_in <= '0;
    out_stall     <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      take_results();
    join_none

    // Directed opening: empty queues first, the unused mode, both extreme
    // words, a peek, a dequeue that leaves a queue empty again, then enough
    // enqueues to use every entry and one more that must report the store full.
    send_item(MODE_DEQ, 1'b0, '1);
    send_item(MODE_PEEK, 1'b1, '1);
    send_item(MODE_UNUSED, 1'b1, '1);
    send_item(MODE_ENQ, 1'b0, '0);
    send_item(MODE_ENQ, 1'b0, '1);
    send_item(MODE_PEEK, 1'b0, '0);
    send_item(MODE_DEQ, 1'b0, '0);
    send_item(MODE_DEQ, 1'b0, '0);
    for (int k = 0; k < ENTRIES; k++)
      send_item(MODE_ENQ, logic'(k % 2), (k % 2) ? 32'h5A5A_0000 + k : 32'hA5A5_0000 + k);
    send_item(MODE_ENQ, 1'b1, 32'hDEAD_BEEF);
    drain_all();

    // Random part, in stretches of fifty items. Each stretch leans towards
    // filling, draining or neither, so the store swings between full and
    // empty many times; about one stretch in four runs without any idling.
    // Every few stretches the sender waits for all results to come back.
    for (int stretch = 0; stretch < 29; stretch++) begin
      case ($urandom_range(2))
        0:       lean = LEAN_FILL;
        1:       lean = LEAN_DRAIN;
        default: lean = LEAN_EVEN;
      endcase
      idling_on = ($urandom_range(3) != 0);
      for (int k = 0; k < 50; k++)
        send_item(draw_mode(lean), logic'($urandom_range(1)), draw_word());
      if (sb.free_count() == 0) n_refills++;
      if (stretch % 6 == 5) drain_all();
    end
    in_valid <= 1'b0;

    // Let the last results arrive, then allow more than the longest
    // item time so that any stray result is still seen.
    idling_on = 1'b1;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d items over both queues; %0d results checked (%0d ok, %0d store full,",
             n_sent, sb.n_checked, sb.n_ok, sb.n_full);
    $display("%0d queue empty); the store stood full at the end of %0d random stretches.",
             sb.n_empty, n_refills);
    if (sb.failures == 0) begin
      $display("shared_buffer_linked_queues_unit test passed");
    end else begin
      $display("shared_buffer_linked_queues_unit test failed");
    end
    $finish;
  end

endmodule
